// File: hdl/ptec_pkg.sv
//------------------------------------------------------------------------------
// ptec_pkg
// shared constants, register indexes and types of the tot energy calibration
//------------------------------------------------------------------------------
package ptec_pkg;

	localparam int DefaultPixelCols = 256;
	localparam int DefaultPixelRows = 256;

	localparam logic [15:0] RST_DEFAULT_A = 16'd7629;
	localparam logic [19:0] RST_DEFAULT_B = 20'd8546;
	localparam logic [23:0] RST_DEFAULT_C = 24'd29072;
	localparam logic [15:0] RST_DEFAULT_T = 16'd179;

	localparam logic [2:0] REG_TOT_OFFSET  = 3'd0;
	localparam logic [2:0] REG_DEFAULT_A   = 3'd1;
	localparam logic [2:0] REG_DEFAULT_B   = 3'd2;
	localparam logic [2:0] REG_DEFAULT_C   = 3'd3;
	localparam logic [2:0] REG_DEFAULT_T   = 3'd4;
	localparam logic [2:0] REG_GLOBAL_MODE = 3'd5;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_CONVERT = 1'b1;

	localparam logic signed [17:0] E_MAX = 18'sd131071;
	localparam logic signed [17:0] E_MIN = -18'sd131072;

	// discriminant magnitude width (square of a 28-bit v plus 64*a*c)
	localparam int DW = 92;
	localparam int SW = DW / 2;
	// numerator / quotient widths for the divider
	localparam int NW = 52;
	localparam int QW = 52;

	typedef struct packed {
		logic              used_default;
		logic              invalid;
		logic [15:0]       a;
		logic signed [47:0] u;
	} ptec_job_t;

	typedef struct packed {
		logic              invalid;
		logic              used_default;
		logic signed [17:0] energy;
		logic              saturated;
	} ptec_res_t;

endpackage

// File: hdl/ptec_engine.sv
//------------------------------------------------------------------------------
// ptec_engine
// iterative square root and divide for one conversion at a time
//------------------------------------------------------------------------------
module ptec_engine
	import ptec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ptec_job_t            job,
	input  logic [DW-1:0]        disc,
	output logic                 busy,
	output logic                 done,
	output ptec_res_t            res
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQRT = 5'b00010,
		ST_NUM  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} eng_state_t;

	eng_state_t         state_q;
	logic [5:0]         cnt_q;
	ptec_job_t          job_q;
	logic [DW-1:0]      rem_q;
	logic [DW-1:0]      root_q;
	logic [DW-1:0]      bit_q;
	logic [DW-1:0]      trial;
	logic [NW-1:0]      num_q;
	logic [NW-1:0]      drem_q;
	logic [NW:0]        dtry;
	logic [QW-1:0]      quo_q;
	logic               neg_q;
	logic [16:0]        dvs;
	logic signed [48:0] n_full;
	logic [48:0]        n_mag;
	logic [NW-1:0]      num_init;
	logic signed [QW:0] q_s;
	logic signed [17:0] e_val;
	logic               e_sat;

	assign dvs    = {job_q.a, 1'b0};
	assign trial  = root_q + bit_q;
	assign dtry   = {drem_q, num_q[NW-1]};
	assign n_full = 49'(job_q.u) + 49'(signed'({1'b0, root_q[SW-1:0]}));
	assign n_mag  = n_full[48] ? 49'(-n_full) : n_full;
	// numerator of the rounded divide: |N|*16 + a
	assign num_init = NW'({n_mag, 4'b0}) + NW'(job_q.a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= job.invalid ? ST_DONE : ST_SQRT;
						cnt_q   <= 6'(SW - 1);
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) state_q <= ST_NUM;
					else cnt_q <= cnt_q - 6'd1;
				end
				ST_NUM: begin
					state_q <= ST_DIV;
					cnt_q   <= 6'(NW - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0) state_q <= ST_DONE;
					else cnt_q <= cnt_q - 6'd1;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					job_q  <= job;
					rem_q  <= disc;
					root_q <= '0;
					bit_q  <= {2'b01, {(DW-2){1'b0}}};
				end
			end
			ST_SQRT: begin
				// one root bit per cycle
				if (rem_q >= trial) begin
					rem_q  <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_NUM: begin
				num_q  <= num_init;
				drem_q <= '0;
				quo_q  <= '0;
				neg_q  <= n_full[48];
			end
			ST_DIV: begin
				// restoring divide by 2a, one quotient bit per cycle
				if (dtry >= (NW+1)'(dvs)) begin
					drem_q <= NW'(dtry - (NW+1)'(dvs));
					quo_q  <= {quo_q[QW-2:0], 1'b1};
				end else begin
					drem_q <= dtry[NW-1:0];
					quo_q  <= {quo_q[QW-2:0], 1'b0};
				end
				num_q <= {num_q[NW-2:0], 1'b0};
			end
			default: ;
		endcase
	end

	assign q_s = neg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
	always_comb begin
		e_sat = 1'b0;
		e_val = q_s[17:0];
		if (q_s > (QW+1)'(E_MAX)) begin
			e_val = E_MAX; e_sat = 1'b1;
		end else if (q_s < (QW+1)'(E_MIN)) begin
			e_val = E_MIN; e_sat = 1'b1;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	always_comb begin
		res.invalid      = job_q.invalid;
		res.used_default = job_q.used_default;
		res.energy       = job_q.invalid ? '0 : e_val;
		res.saturated    = job_q.invalid ? 1'b0 : e_sat;
	end

endmodule

// File: hdl/per_pixel_tot_energy_calibration.sv
//------------------------------------------------------------------------------
// per_pixel_tot_energy_calibration
// per-pixel tot to energy conversion with coefficient memory
//------------------------------------------------------------------------------
// channel   dir  handshake          contents
// s_axis    in   tvalid/tready      command, pixel, tot, load coefficients
// m_axis    out  tvalid/tready      energy and flags, one per convert
// apb       in   psel/penable       six calibration registers
//
// a load is taken and the next item may follow right away.
// a convert offers its result after the memory read, two product stages,
// a 46 step square root, a numerator step and a 52 step divider, one bit a
// cycle; an invalid job skips the square root, numerator and divider.
// after reset the a memory is swept to zero, one pixel a cycle, while no
// transfer is accepted. no new item is taken until a convert's result
// has been accepted on m_axis.
//------------------------------------------------------------------------------
module per_pixel_tot_energy_calibration
	import ptec_pkg::*;
#(
	parameter int PIXEL_COLS = DefaultPixelCols,
	parameter int PIXEL_ROWS = DefaultPixelRows
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: pixel_col[7:0] pixel_row[15:8] tot_count[29:16] load_a[45:30]
	//        load_b[65:46] load_c[89:66] load_t[105:90], zero fill to 112
	input  logic [111:0] s_axis_tdata,
	// tuser: command
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: energy[17:0] invalid[18] used_default[19] saturated[20]
	output logic [23:0]  m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int NPIX = PIXEL_COLS * PIXEL_ROWS;
	localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;

	// configuration registers
	logic [15:0] tot_offset_q, default_a_q, default_t_q;
	logic [19:0] default_b_q;
	logic [23:0] default_c_q;
	logic        global_mode_q;
	logic [2:0]  reg_idx;
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_offset_q  <= '0;
			default_a_q   <= RST_DEFAULT_A;
			default_b_q   <= RST_DEFAULT_B;
			default_c_q   <= RST_DEFAULT_C;
			default_t_q   <= RST_DEFAULT_T;
			global_mode_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_TOT_OFFSET:  tot_offset_q  <= pwdata[15:0];
				REG_DEFAULT_A:   default_a_q   <= pwdata[15:0];
				REG_DEFAULT_B:   default_b_q   <= pwdata[19:0];
				REG_DEFAULT_C:   default_c_q   <= pwdata[23:0];
				REG_DEFAULT_T:   default_t_q   <= pwdata[15:0];
				REG_GLOBAL_MODE: global_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TOT_OFFSET:  prdata = {16'd0, tot_offset_q};
			REG_DEFAULT_A:   prdata = {16'd0, default_a_q};
			REG_DEFAULT_B:   prdata = {{12{default_b_q[19]}}, default_b_q};
			REG_DEFAULT_C:   prdata = {{8{default_c_q[23]}}, default_c_q};
			REG_DEFAULT_T:   prdata = {{16{default_t_q[15]}}, default_t_q};
			REG_GLOBAL_MODE: prdata = {31'd0, global_mode_q};
			default:         prdata = '0;
		endcase
	end

	// input fields
	logic [7:0]  in_col, in_row;
	logic [13:0] in_tot;
	logic [15:0] in_a, in_t;
	logic [19:0] in_b;
	logic [23:0] in_c;
	assign in_col = s_axis_tdata[7:0];
	assign in_row = s_axis_tdata[15:8];
	assign in_tot = s_axis_tdata[29:16];
	assign in_a   = s_axis_tdata[45:30];
	assign in_b   = s_axis_tdata[65:46];
	assign in_c   = s_axis_tdata[89:66];
	assign in_t   = s_axis_tdata[105:90];

	logic in_range;
	logic [AW-1:0] in_idx;
	assign in_range = (32'(in_col) < PIXEL_COLS) && (32'(in_row) < PIXEL_ROWS);
	assign in_idx = AW'(32'(in_col) * PIXEL_ROWS + 32'(in_row));

	// control: clear sweep, front stage, engine, result register
	typedef enum logic [3:0] {
		CT_CLEAR = 4'b0001,
		CT_IDLE  = 4'b0010,
		CT_READ  = 4'b0100,
		CT_CALC  = 4'b1000
	} ctl_state_t;

	ctl_state_t   ctl_q;
	logic [AW:0]  clr_cnt_q;
	logic         busy_eng, done_eng, start_eng;
	ptec_res_t    eng_res;
	logic         s_acc;

	assign s_axis_tready = (ctl_q == CT_IDLE) && !m_axis_tvalid;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// coefficient memories, one synchronous read port each
	logic [15:0] mem_a [NPIX];
	logic [59:0] mem_bct [NPIX];
	logic [15:0] rd_a_s1;
	logic [59:0] rd_bct_s1;

	logic          wr_en;
	logic [AW-1:0] wr_idx;
	logic [15:0]   wr_a;
	assign wr_en  = (ctl_q == CT_CLEAR) || (s_acc && s_axis_tuser == CMD_LOAD && in_range);
	assign wr_idx = (ctl_q == CT_CLEAR) ? clr_cnt_q[AW-1:0] : in_idx;
	assign wr_a   = (ctl_q == CT_CLEAR) ? 16'd0 : in_a;

	always_ff @(posedge clk) begin
		if (wr_en) mem_a[wr_idx] <= wr_a;
		rd_a_s1 <= mem_a[in_idx];
	end
	always_ff @(posedge clk) begin
		if (s_acc && s_axis_tuser == CMD_LOAD && in_range)
			mem_bct[in_idx] <= {in_t, in_c, in_b};
		rd_bct_s1 <= mem_bct[in_idx];
	end

	// request fields held for the read cycle
	logic        in_range_s1;
	logic [13:0] tot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q     <= CT_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			case (ctl_q)
				CT_CLEAR: begin
					// sweep the a memory to zero
					if (clr_cnt_q == (AW+1)'(NPIX - 1)) ctl_q <= CT_IDLE;
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
				CT_IDLE: if (s_acc && s_axis_tuser == CMD_CONVERT) ctl_q <= CT_READ;
				CT_READ: ctl_q <= CT_CALC;
				CT_CALC: if (done_eng) ctl_q <= CT_IDLE;
				default: ctl_q <= CT_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			in_range_s1 <= in_range;
			tot_s1      <= in_tot;
		end
	end

	// coefficient selection and the wide products, in the read cycle
	logic               dflt;
	logic [15:0]        ca;
	logic signed [19:0] cb;
	logic signed [23:0] cc;
	logic signed [15:0] ct;
	assign dflt = global_mode_q || !in_range_s1 || rd_a_s1 == 16'd0;
	assign ca = dflt ? default_a_q : rd_a_s1;
	assign cb = dflt ? signed'(default_b_q) : signed'(rd_bct_s1[19:0]);
	assign cc = dflt ? signed'(default_c_q) : signed'(rd_bct_s1[43:20]);
	assign ct = dflt ? signed'(default_t_q) : signed'(rd_bct_s1[59:44]);

	// stage 2 registers: P, d, a*c
	logic signed [32:0] ta_full;
	logic signed [24:0] p_val;
	logic signed [20:0] x_val;
	logic signed [26:0] d_val;
	logic signed [41:0] ac_val;
	assign ta_full = 33'(ct) * 33'(signed'({1'b0, ca}));
	// truncate toward zero
	assign p_val = 25'((ta_full + ((ta_full < 0) ? 33'sd255 : 33'sd0)) >>> 8);
	assign x_val = 21'(signed'({1'b0, tot_s1, 4'b0})) - 21'(signed'({1'b0, tot_offset_q}));
	assign d_val = 27'((22'(x_val) - 22'(cb))) <<< 4;
	assign ac_val = 42'(cc) * 42'(signed'({1'b0, ca}));

	logic signed [24:0] p_s2;
	logic signed [26:0] d_s2;
	logic signed [41:0] ac_s2;
	logic [15:0]        a_s2;
	logic               dflt_s2, go_s2, go_s3;
	always_ff @(posedge clk) begin
		p_s2    <= p_val;
		d_s2    <= d_val;
		ac_s2   <= ac_val;
		a_s2    <= ca;
		dflt_s2 <= dflt;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s2 <= 1'b0;
			go_s3 <= 1'b0;
		end else begin
			go_s2 <= (ctl_q == CT_READ);
			go_s3 <= go_s2;
		end
	end

	// stage 3: square of v, then discriminant
	logic signed [27:0] u_val, v_val;
	assign u_val = 28'(p_s2) + 28'(d_s2);
	assign v_val = 28'(p_s2) - 28'(d_s2);
	logic [55:0]        vv_s3;
	logic signed [47:0] ac64_s3;
	logic signed [27:0] u_s3;
	logic [15:0]        a_s3;
	logic               dflt_s3;
	always_ff @(posedge clk) begin
		vv_s3   <= 56'(56'(v_val) * 56'(v_val));
		ac64_s3 <= 48'(ac_s2) <<< 6;
		u_s3    <= u_val;
		a_s3    <= a_s2;
		dflt_s3 <= dflt_s2;
	end

	logic signed [57:0] disc_s;
	assign disc_s = 58'(signed'({1'b0, vv_s3})) + 58'(ac64_s3);

	ptec_job_t job;
	assign job.used_default = dflt_s3;
	assign job.invalid      = (a_s3 == 16'd0) || disc_s[57];
	assign job.a            = a_s3;
	assign job.u            = 48'(u_s3);

	assign start_eng = go_s3;

	ptec_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_eng),
		.job    (job),
		.disc   (DW'(disc_s[56:0])),
		.busy   (busy_eng),
		.done   (done_eng),
		.res    (eng_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (done_eng) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (done_eng)
			m_axis_tdata <= {3'd0, eng_res.saturated, eng_res.used_default,
				eng_res.invalid, eng_res.energy};
	end

	// no new transfer while a conversion is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !busy_eng)
		else $error("input taken while engine busy");
	// a result only appears after a conversion was started
	assert property (@(posedge clk) disable iff (!arst_n)
		done_eng |-> ctl_q == CT_CALC)
		else $error("engine done outside a conversion");
	// invalid results carry zero energy
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[17:0] == '0)
		else $error("invalid result with nonzero energy");

endmodule
